// ===== hw/rtl/tw_pkg.sv =====
`timescale 1ns / 1ps

package tw_pkg;

  localparam int RAW_W    = 24;
  localparam int SUM_W    = 28;
  localparam int GAIN_W   = 17;
  localparam int CNT_W    = 4;
  localparam int WEIGHT_W = 24;
  localparam int FUNC_W   = 2;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam int TARE_SAMPLES_DEF = 5;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Cycles from loading a sum into the divider until its quotient is registered.
  localparam int DIV_LAT   = 4;
  localparam int DIV_CNT_W = 3;

  localparam logic signed [GAIN_W-1:0] GAIN_LEFT_RST  = 17'sd7664;
  localparam logic signed [GAIN_W-1:0] GAIN_RIGHT_RST = -17'sd7381;

  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TARE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LAST = 2'd2;

  localparam logic [KIND_W-1:0] KIND_READ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STAT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     fin;
    logic signed [RAW_W-1:0]  raw_left;
    logic signed [RAW_W-1:0]  raw_right;
    logic signed [SUM_W-1:0]  sum_left;
    logic signed [SUM_W-1:0]  sum_right;
    logic                     connected;
    logic                     taring;
  } tw_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              connected;
    logic              taring;
  } tw_tag_t;

endpackage

// ===== hw/rtl/tw_if.sv =====
`timescale 1ns / 1ps

interface tw_in_if;
  import tw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [RAW_W-1:0] raw_left;
  logic signed [RAW_W-1:0] raw_right;
  logic                    cells_present;

  modport source (output valid, func, raw_left, raw_right, cells_present, input ready);
  modport sink (input valid, func, raw_left, raw_right, cells_present, output ready);
endinterface

interface tw_out_if;
  import tw_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] weight;
  logic                       weight_valid;
  logic                       connected;
  logic                       taring;

  modport source (output valid, weight, weight_valid, connected, taring, input ready);
  modport sink (input valid, weight, weight_valid, connected, taring, output ready);
endinterface

// ===== hw/rtl/tw_front.sv =====
`timescale 1ns / 1ps

module tw_front import tw_pkg::*; #(
  parameter int TARE_SAMPLES = TARE_SAMPLES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tw_in_if.sink      sample,
  output tw_entry_t  entry,
  output logic       entry_valid,
  input  logic       entry_ready
);

  logic signed [RAW_W-1:0] last_left, last_left_next;
  logic signed [RAW_W-1:0] last_right, last_right_next;
  logic signed [SUM_W-1:0] sum_left, sum_left_next;
  logic signed [SUM_W-1:0] sum_right, sum_right_next;
  logic [CNT_W-1:0]        tare_count, tare_count_next;
  logic                    tare_active, tare_active_next;
  logic                    present_flag, present_flag_next;
  logic                    accept;

  assign sample.ready = entry_ready;
  assign entry_valid  = sample.valid;
  assign accept       = sample.valid && entry_ready;

  always_comb begin
    last_left_next    = last_left;
    last_right_next   = last_right;
    sum_left_next     = sum_left;
    sum_right_next    = sum_right;
    tare_count_next   = tare_count;
    tare_active_next  = tare_active;
    present_flag_next = present_flag;
    entry.kind        = KIND_STAT;
    entry.fin         = 1'b0;
    entry.raw_left    = last_left;
    entry.raw_right   = last_right;
    case (sample.func)
      FUNC_READ: begin
        last_left_next    = sample.raw_left;
        last_right_next   = sample.raw_right;
        present_flag_next = sample.cells_present;
        entry.kind        = KIND_READ;
        entry.raw_left    = sample.raw_left;
        entry.raw_right   = sample.raw_right;
        if (tare_active) begin
          sum_left_next   = sum_left + SUM_W'(sample.raw_left);
          sum_right_next  = sum_right + SUM_W'(sample.raw_right);
          tare_count_next = tare_count + CNT_W'(1);
          if (tare_count_next >= CNT_W'(TARE_SAMPLES)) begin
            tare_active_next = 1'b0;
            entry.fin        = 1'b1;
          end
        end
      end
      FUNC_TARE: begin
        if (present_flag) begin
          tare_active_next = 1'b1;
          tare_count_next  = '0;
          sum_left_next    = '0;
          sum_right_next   = '0;
        end
      end
      FUNC_LAST: begin
        if (present_flag) begin
          entry.kind = KIND_LOAD;
        end
      end
      default: begin
      end
    endcase
    entry.sum_left  = sum_left_next;
    entry.sum_right = sum_right_next;
    entry.connected = present_flag_next;
    entry.taring    = present_flag_next && tare_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left    <= '0;
      last_right   <= '0;
      sum_left     <= '0;
      sum_right    <= '0;
      tare_count   <= '0;
      tare_active  <= 1'b1;
      present_flag <= 1'b0;
    end else if (accept) begin
      last_left    <= last_left_next;
      last_right   <= last_right_next;
      sum_left     <= sum_left_next;
      sum_right    <= sum_right_next;
      tare_count   <= tare_count_next;
      tare_active  <= tare_active_next;
      present_flag <= present_flag_next;
    end
  end

endmodule

// ===== hw/rtl/tw_fifo.sv =====
`timescale 1ns / 1ps

module tw_fifo import tw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  tw_entry_t wdata,
  input  logic      push_valid,
  output logic      push_ready,
  output tw_entry_t rdata,
  output logic      pop_valid,
  input  logic      pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  tw_entry_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W_Q-1:0] fill;
  logic               push;
  logic               pop;

  assign push_ready = (fill != CNT_W_Q'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign rdata      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W_Q'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W_Q'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/tw_div.sv =====
`timescale 1ns / 1ps

module tw_div import tw_pkg::*; #(
  parameter int DIVISOR = TARE_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic signed [SUM_W-1:0] dividend,
  output logic signed [RAW_W-1:0] quotient
);

  // The reciprocal estimate is low by at most one; the remainder check fixes it.
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SUM_W) / DIVISOR);
  localparam logic [SUM_W-1:0]   DIV_C = SUM_W'(DIVISOR);

  logic [SUM_W-1:0]  mag1, mag2, q0_3;
  logic              neg1, neg2, neg3, corr3;
  logic [PROD_W-1:0] prod2;
  logic [SUM_W-1:0]  q0;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  q_fix;

  assign q0    = prod2[SUM_W +: SUM_W];
  assign rem   = mag2 - q0 * DIV_C;
  assign q_fix = q0_3 + SUM_W'(corr3);

  always_ff @(posedge clk) begin
    neg1     <= dividend[SUM_W-1];
    mag1     <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    neg2     <= neg1;
    mag2     <= mag1;
    prod2    <= PROD_W'(mag1) * PROD_W'(RECIP);
    neg3     <= neg2;
    q0_3     <= q0;
    corr3    <= (rem >= DIV_C);
    quotient <= neg3 ? RAW_W'(-q_fix) : RAW_W'(q_fix);
  end

endmodule

// ===== hw/rtl/tw_back.sv =====
`timescale 1ns / 1ps

module tw_back import tw_pkg::*; #(
  parameter int TARE_SAMPLES = TARE_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  tw_entry_t            entry,
  input  logic                 entry_valid,
  output logic                 entry_ready,
  tw_out_if.source             result
);

  localparam int DIFF_W = RAW_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W;
  localparam int PART_W = PROD_W - 16;
  localparam int SUMW_W = PART_W + 1;
  localparam logic signed [SUMW_W-1:0] W_MAX = SUMW_W'(8388607);
  localparam logic signed [SUMW_W-1:0] W_MIN = -SUMW_W'(8388608);

  logic signed [GAIN_W-1:0]   gain_left, gain_right;
  logic signed [RAW_W-1:0]    offset_left, offset_right;
  logic signed [RAW_W-1:0]    off_use_left, off_use_right;
  logic signed [RAW_W-1:0]    div_left, div_right;

  tw_entry_t                  s0;
  logic                       s0_valid;
  logic [DIV_CNT_W-1:0]       div_cnt;
  logic                       adv, s0_go, load;

  logic                       w1_valid, w2_valid;
  tw_tag_t                    w1_tag, w2_tag;
  logic signed [DIFF_W-1:0]   d_left, d_right;
  logic signed [PROD_W-1:0]   p_left, p_right;
  logic signed [SUMW_W-1:0]   w_sum;
  logic signed [WEIGHT_W-1:0] w_sat;

  logic signed [WEIGHT_W-1:0] held_weight;
  logic                       held_valid;
  logic                       out_valid;
  logic signed [WEIGHT_W-1:0] out_weight;
  logic                       out_weight_valid, out_connected, out_taring;

  tw_div #(.DIVISOR(TARE_SAMPLES)) u_div_left (
    .clk      (clk),
    .dividend (s0.sum_left),
    .quotient (div_left)
  );

  tw_div #(.DIVISOR(TARE_SAMPLES)) u_div_right (
    .clk      (clk),
    .dividend (s0.sum_right),
    .quotient (div_right)
  );

  assign adv         = !out_valid || result.ready;
  assign s0_go       = s0_valid && adv && (!s0.fin || div_cnt == DIV_CNT_W'(DIV_LAT));
  assign entry_ready = !s0_valid || s0_go;
  assign load        = entry_valid && entry_ready;

  // A reading that closes the tare uses the freshly divided offsets.
  assign off_use_left  = s0.fin ? div_left : offset_left;
  assign off_use_right = s0.fin ? div_right : offset_right;

  assign w_sum = SUMW_W'($signed(p_left[PROD_W-1:16]))
               + SUMW_W'($signed(p_right[PROD_W-1:16]));

  always_comb begin
    if (w_sum > W_MAX) begin
      w_sat = WEIGHT_W'(W_MAX);
    end else if (w_sum < W_MIN) begin
      w_sat = WEIGHT_W'(W_MIN);
    end else begin
      w_sat = WEIGHT_W'(w_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_left  <= GAIN_LEFT_RST;
      gain_right <= GAIN_RIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_LEFT: begin
          gain_left <= cfg_data;
        end
        CFG_GAIN_RIGHT: begin
          gain_right <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      div_cnt  <= '0;
    end else if (load) begin
      s0_valid <= 1'b1;
      div_cnt  <= '0;
    end else if (s0_go) begin
      s0_valid <= 1'b0;
    end else if (s0_valid && s0.fin && div_cnt != DIV_CNT_W'(DIV_LAT)) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (load) begin
      s0 <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_left  <= '0;
      offset_right <= '0;
    end else if (s0_go) begin
      case (s0.kind)
        KIND_LOAD: begin
          offset_left  <= s0.raw_left;
          offset_right <= s0.raw_right;
        end
        KIND_READ: begin
          if (s0.fin) begin
            offset_left  <= div_left;
            offset_right <= div_right;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w1_valid    <= 1'b0;
      w2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      held_weight <= '0;
      held_valid  <= 1'b0;
    end else if (adv) begin
      w1_valid  <= s0_go;
      w2_valid  <= w1_valid;
      out_valid <= w2_valid;
      if (w2_valid && w2_tag.kind == KIND_READ) begin
        held_weight <= w_sat;
        held_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_tag  <= '{kind: s0.kind, connected: s0.connected, taring: s0.taring};
      d_left  <= DIFF_W'(s0.raw_left) - DIFF_W'(off_use_left);
      d_right <= DIFF_W'(s0.raw_right) - DIFF_W'(off_use_right);
      w2_tag  <= w1_tag;
      p_left  <= d_left * gain_left;
      p_right <= d_right * gain_right;
      if (w2_tag.kind == KIND_READ) begin
        out_weight       <= w_sat;
        out_weight_valid <= 1'b1;
      end else begin
        out_weight       <= held_weight;
        out_weight_valid <= held_valid;
      end
      out_connected <= w2_tag.connected;
      out_taring    <= w2_tag.taring;
    end
  end

  assign result.valid        = out_valid;
  assign result.weight       = out_weight;
  assign result.weight_valid = out_weight_valid;
  assign result.connected    = out_connected;
  assign result.taring       = out_taring;

endmodule

// ===== hw/rtl/dual_load_cell_tare_weigher_unit.sv =====
`timescale 1ns / 1ps

// Dual load cell tare weigher. Each word on the sample channel yields exactly one
// word on the result channel, in order. The block accepts one sample word per
// clock while the queue has room; a queue of QUEUE_DEPTH words parts the front,
// which keeps the tare sums and classifies each word, from the back, which holds
// the offsets and computes the weight. A word leaving the queue is registered in
// s0, then passes the difference, multiply and saturate stages. A reading that
// completes a tare holds the back while both sums pass through the constant
// divider, and the queue absorbs that pause. The user must write gains through
// cfg_we, cfg_index and cfg_data while no word is in flight; nothing enforces it.
module dual_load_cell_tare_weigher_unit import tw_pkg::*; #(
  parameter int TARE_SAMPLES = TARE_SAMPLES_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  tw_in_if.sink                sample,
  tw_out_if.source             result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  tw_entry_t front_entry;
  logic      front_valid;
  logic      front_ready;
  tw_entry_t back_entry;
  logic      back_valid;
  logic      back_ready;

  tw_front #(.TARE_SAMPLES(TARE_SAMPLES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .entry       (front_entry),
    .entry_valid (front_valid),
    .entry_ready (front_ready)
  );

  tw_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wdata      (front_entry),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .rdata      (back_entry),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  tw_back #(.TARE_SAMPLES(TARE_SAMPLES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .entry       (back_entry),
    .entry_valid (back_valid),
    .entry_ready (back_ready),
    .result      (result)
  );

endmodule
